// ----- rtl/core/key_short_long_press_detector_unit_assert.svh -----
// Assertion macros shared by the key press detector RTL.
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KSLP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("key press detector check failed");
`define KSLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key press detector sequence check failed");
`else
`define KSLP_ASSERT(label, clk, rst, prop)
`define KSLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/kslp_pkg.sv -----
// Types and constants shared by the key press detector modules.
package kslp_pkg;

   localparam int NUM_KEYS = 2;
   localparam int KEY_W    = 1;
   localparam int CNT_W    = 2;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

   localparam logic OP_TICK        = 1'b0;
   localparam logic OP_EDGE        = 1'b1;
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;
   localparam logic KIND_SHORT     = 1'b0;
   localparam logic KIND_LONG      = 1'b1;

   localparam logic CSR_DEBOUNCE   = 1'b0;
   localparam logic CSR_LONG_PRESS = 1'b1;

   typedef struct packed {
      logic event_key;
      logic event_kind;
      logic last_event;
   } rsp_word_type;

   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      rsp_word_type [NUM_KEYS-1:0]       word;
   } push_type;

endpackage

// ----- rtl/core/key_short_long_press_detector_unit.sv -----
// Top level of the two-key short and long press detector.
// The block classifies presses of two keys from a stream of words: a tick word advances a
// 32-bit millisecond counter and reports a long press for every held key whose hold time has
// reached long_press_ms, and an edge word carries one key's pin level (low is a press, high a
// release) and may report a short press on release. A press is accepted only when more than
// debounce_ms have passed since that key's last accepted press. An accepted word is classified
// while it sits in the input register, once the result queue has room for all its results,
// and its results are written into the queue at the end of that cycle; a result written into
// an empty queue is offered in the following cycle. One input word can be accepted every
// cycle while the queue has room; a tick that reports two long presses writes both result
// words into the queue at once, and the result queue's single read port (one word per cycle)
// together with the need for two free queue slots before a word is classified sets the
// sustained rate when the result side stalls or when long presses pile up.
module key_short_long_press_detector_unit #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input words.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [kslp_pkg::KEY_W-1:0]    req_key_index,
   input  logic                          req_pin_level,
   // Result words.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kslp_pkg::KEY_W-1:0]    rsp_event_key,
   output logic                          rsp_event_kind,
   output logic                          rsp_last_event,
   // Register writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [kslp_pkg::CFG_W-1:0]    csr_data
);

   // Input register: holds one word until the result queue has room for its results.
   logic                         item_valid_ff;
   logic                         item_valid_in;
   logic                         item_op_ff;
   logic [kslp_pkg::KEY_W-1:0]   item_key_ff;
   logic                         item_level_ff;
   logic                         req_take;
   logic                         process_fire;
   logic                         room;

   // Configuration registers.
   logic [kslp_pkg::CFG_W-1:0]   debounce_ff;
   logic [kslp_pkg::CFG_W-1:0]   long_press_ff;

   kslp_pkg::push_type           push;
   kslp_pkg::rsp_word_type       rsp_word;

   // A word is classified once the queue is sure to hold every result it may make, so the
   // input register is free again in the same cycle and the next word can move in.
   assign process_fire  = item_valid_ff && room;
   assign req_ready     = !item_valid_ff || process_fire;
   assign req_take      = req_valid && req_ready;
   assign item_valid_in = req_take || (item_valid_ff && !process_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_op_ff    <= req_operation;
         item_key_ff   <= req_key_index;
         item_level_ff <= req_pin_level;
      end
   end

   // Always taken unchecked; the user must issue register writes only while the block is idle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= kslp_pkg::DEBOUNCE_RESET;
         long_press_ff <= kslp_pkg::LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kslp_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_data;
            kslp_pkg::CSR_LONG_PRESS: long_press_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   kslp_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .fire          (process_fire),
      .operation     (item_op_ff),
      .key_index     (item_key_ff),
      .pin_level     (item_level_ff),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .push          (push)
   );

   kslp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_event_key  = rsp_word.event_key;
   assign rsp_event_kind = rsp_word.event_kind;
   assign rsp_last_event = rsp_word.last_event;

endmodule

// ----- rtl/core/kslp_classify.sv -----
// Key state, millisecond counter, press classification: one word per fired cycle.
`include "key_short_long_press_detector_unit_assert.svh"
module kslp_classify (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic                             operation,
   input  logic [kslp_pkg::KEY_W-1:0]       key_index,
   input  logic                             pin_level,
   input  logic [kslp_pkg::CFG_W-1:0]       debounce_ms,
   input  logic [kslp_pkg::CFG_W-1:0]       long_press_ms,
   output kslp_pkg::push_type               push
);

   logic [kslp_pkg::TIME_W-1:0] ms_ff;
   logic [kslp_pkg::TIME_W-1:0] ms_in;
   logic [kslp_pkg::TIME_W-1:0] stamp_ff [kslp_pkg::NUM_KEYS];
   logic [kslp_pkg::NUM_KEYS-1:0] held_ff;
   logic [kslp_pkg::NUM_KEYS-1:0] fired_ff;
   logic [kslp_pkg::NUM_KEYS-1:0] long_hit;
   logic [kslp_pkg::TIME_W-1:0] edge_age;
   logic [kslp_pkg::TIME_W-1:0] long_ext;
   logic                         press_ok;
   logic                         short_hit;

   assign ms_in    = ms_ff + kslp_pkg::TIME_W'(1);
   assign long_ext = {{(kslp_pkg::TIME_W-kslp_pkg::CFG_W){1'b0}}, long_press_ms};
   assign edge_age = ms_ff - stamp_ff[key_index];
   assign press_ok = edge_age >
                     {{(kslp_pkg::TIME_W-kslp_pkg::CFG_W){1'b0}}, debounce_ms};
   assign short_hit = held_ff[key_index] && !fired_ff[key_index] && (edge_age < long_ext);

   // Long press test uses the time after this tick's increment.
   always_comb begin
      for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
         long_hit[k] = held_ff[k] && !fired_ff[k] && ((ms_in - stamp_ff[k]) >= long_ext);
      end
   end

   always_comb begin
      logic [kslp_pkg::CNT_W-1:0] cnt;
      cnt  = '0;
      push = '0;
      if (fire) begin
         if (operation == kslp_pkg::OP_TICK) begin
            for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
               if (long_hit[k]) begin
                  push.word[cnt[kslp_pkg::KEY_W-1:0]].event_key  = kslp_pkg::KEY_W'(k);
                  push.word[cnt[kslp_pkg::KEY_W-1:0]].event_kind = kslp_pkg::KIND_LONG;
                  cnt = cnt + kslp_pkg::CNT_W'(1);
               end
            end
         end else if (pin_level == kslp_pkg::LEVEL_RELEASED && short_hit) begin
            push.word[0].event_key  = key_index;
            push.word[0].event_kind = kslp_pkg::KIND_SHORT;
            cnt = kslp_pkg::CNT_W'(1);
         end
         if (cnt != '0) begin
            push.word[kslp_pkg::KEY_W'(cnt - kslp_pkg::CNT_W'(1))].last_event = 1'b1;
         end
      end
      push.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff    <= '0;
         held_ff  <= '0;
         fired_ff <= '0;
         for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
            stamp_ff[k] <= '0;
         end
      end else if (fire) begin
         if (operation == kslp_pkg::OP_TICK) begin
            ms_ff    <= ms_in;
            fired_ff <= fired_ff | long_hit;
         end else if (pin_level == kslp_pkg::LEVEL_PRESSED) begin
            if (press_ok) begin
               stamp_ff[key_index] <= ms_ff;
               held_ff[key_index]  <= 1'b1;
               fired_ff[key_index] <= 1'b0;
            end
         end else if (held_ff[key_index]) begin
            held_ff[key_index]  <= 1'b0;
            fired_ff[key_index] <= 1'b0;
         end
      end
   end

   `KSLP_ASSERT(a_edge_one_word, clock, reset,
      (fire && operation == kslp_pkg::OP_EDGE) |-> (push.count <= kslp_pkg::CNT_W'(1)))
   `KSLP_ASSERT(a_fired_only_held, clock, reset, ((fired_ff & ~held_ff) == '0))
   `KSLP_ASSERT_NEXT(a_tick_advances, clock, reset,
      fire && operation == kslp_pkg::OP_TICK, ms_ff == $past(ms_ff) + kslp_pkg::TIME_W'(1))

endmodule

// ----- rtl/core/kslp_rsp_fifo.sv -----
// Result queue that takes up to two words a cycle and hands out one.
`include "key_short_long_press_detector_unit_assert.svh"
module kslp_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  kslp_pkg::push_type      push,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output kslp_pkg::rsp_word_type  rsp_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   kslp_pkg::rsp_word_type mem [DEPTH];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] wr_in;
   logic [PW-1:0] rd_ff;
   logic [PW-1:0] rd_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_after_pop;
   logic          pop;

   function automatic logic [PW-1:0] ptr_add(logic [PW-1:0] p, logic [PW-1:0] n);
      logic [PW:0] sum;
      sum = {1'b0, p} + {1'b0, n};
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   assign pop             = rsp_valid && rsp_ready;
   assign rsp_valid       = count_ff != '0;
   assign rsp_word        = mem[rd_ff];
   assign count_after_pop = count_ff - CW'(pop);
   assign room            = count_after_pop <= CW'(DEPTH - kslp_pkg::NUM_KEYS);
   assign count_in        = count_after_pop + CW'(push.count);
   assign wr_in           = ptr_add(wr_ff, PW'(push.count));
   assign rd_in           = pop ? ptr_add(rd_ff, PW'(1)) : rd_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < kslp_pkg::NUM_KEYS; i++) begin
         if (kslp_pkg::CNT_W'(i) < push.count) begin
            mem[ptr_add(wr_ff, PW'(i))] <= push.word[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `KSLP_ASSERT(a_count_bound, clock, reset, (count_ff <= CW'(DEPTH)))
   `KSLP_ASSERT(a_push_fits, clock, reset,
      ((push.count != '0) |-> (count_in <= CW'(DEPTH))))
   `KSLP_ASSERT_NEXT(a_pop_drains, clock, reset,
      pop && push.count == '0, count_ff == $past(count_ff) - CW'(1))

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-key short and long press detector.
module tb;
   import kslp_pkg::*;

   // Clock period is 12 ns. The cycle limit is far above the slowest legal run of about
   // 1400 words, each with long sender gaps, up to two results per word and long
   // receiver stalls.
   localparam int HALF_PERIOD   = 6;
   localparam int CYCLE_LIMIT   = 400000;
   // The block classifies a word while it sits in its input register, once the result
   // queue has room. A word that causes no result can still be in flight when the last
   // result has left, so register writes also wait out SETTLE_CYCLES after the drain.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 20;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic               req_operation  = OP_TICK;
   logic [KEY_W-1:0]   req_key_index  = '0;
   logic               req_pin_level  = LEVEL_RELEASED;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [KEY_W-1:0]   rsp_event_key;
   logic               rsp_event_kind;
   logic               rsp_last_event;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic               csr_index      = CSR_DEBOUNCE;
   logic [CFG_W-1:0]   csr_data       = '0;

   // Idling control. The sender holds back a word with the first chance, the receiver
   // drops ready with the second, both in percent.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int cycle_count    = 0;
   int mismatch_count = 0;

   // Our own copy of the key state and the two registers. It is advanced at the edge
   // at which a word is accepted, so the expected results line up in word order.
   logic [TIME_W-1:0] ms_now;
   logic [TIME_W-1:0] press_time [NUM_KEYS];
   logic              armed      [NUM_KEYS];
   logic              long_sent  [NUM_KEYS];
   logic [CFG_W-1:0]  debounce_now;
   logic [CFG_W-1:0]  long_press_now;

   // Press events that the block still owes us, oldest first.
   rsp_word_type      pending_events [$];

   key_short_long_press_detector_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_key_index  (req_key_index),
      .req_pin_level  (req_pin_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_key  (rsp_event_key),
      .rsp_event_kind (rsp_event_kind),
      .rsp_last_event (rsp_last_event),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // The watchdog. Any hang, including results that never arrive, ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // The receiver. Ready is redrawn every cycle from the current stall chance.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Works out the events that one accepted word causes and queues them. A tick
   // first advances time and then looks at the keys in order, so two long presses
   // from one tick come out key 0 first.
   task automatic classify_word(input logic op, input logic key, input logic level);
      rsp_word_type      found [$];
      rsp_word_type      one;
      logic [TIME_W-1:0] held;
      if (op == OP_TICK) begin
         ms_now = ms_now + 1'b1;
         for (int k = 0; k < NUM_KEYS; k++) begin
            held = ms_now - press_time[k];
            if (armed[k] && !long_sent[k] && held >= TIME_W'(long_press_now)) begin
               long_sent[k]   = 1'b1;
               one.event_key  = k[0];
               one.event_kind = KIND_LONG;
               one.last_event = 1'b0;
               found.push_back(one);
            end
         end
      end else if (level == LEVEL_PRESSED) begin
         // A press counts only when more than the debounce time has gone by since
         // this key's last accepted press, even if the key is still armed.
         held = ms_now - press_time[key];
         if (held > TIME_W'(debounce_now)) begin
            press_time[key] = ms_now;
            armed[key]      = 1'b1;
            long_sent[key]  = 1'b0;
         end
      end else if (armed[key]) begin
         held = ms_now - press_time[key];
         if (!long_sent[key] && held < TIME_W'(long_press_now)) begin
            one.event_key  = key;
            one.event_kind = KIND_SHORT;
            one.last_event = 1'b0;
            found.push_back(one);
         end
         armed[key]     = 1'b0;
         long_sent[key] = 1'b0;
      end
      if (found.size() > 0)
         found[found.size() - 1].last_event = 1'b1;
      foreach (found[i])
         pending_events.push_back(found[i]);
   endtask

   // Sends one word. It is called at a rising edge and returns at the edge that took
   // the word. Valid is left high so that a following word can go out back to back;
   // it only drops when the sender idles or the stimulus stops. Ready is looked at
   // on the falling edge, where every input has long since settled.
   task automatic send_word(input logic op, input logic key, input logic level);
      bit took;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_index <= key;
      req_pin_level <= level;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      classify_word(op, key, level);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(OP_TICK, 1'b0, LEVEL_RELEASED);
   endtask

   // Stops the input, waits for every owed event and then for the pipeline to empty.
   task automatic settle_block;
      req_valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
      bit took;
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      if (index == CSR_DEBOUNCE)
         debounce_now = value;
      else
         long_press_now = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Every accepted result is held against the oldest owed event. The handshake
   // happens at the next rising edge, and nothing changes between here and there.
   always @(negedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: key %0d kind %0d last %0d",
                                      rsp_event_key, rsp_event_kind, rsp_last_event));
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_key !== want.event_key)
               report_mismatch($sformatf("event_key %0d, wanted %0d",
                                         rsp_event_key, want.event_key));
            if (rsp_event_kind !== want.event_kind)
               report_mismatch($sformatf("event_kind %0d, wanted %0d",
                                         rsp_event_kind, want.event_kind));
            if (rsp_last_event !== want.last_event)
               report_mismatch($sformatf("last_event %0d, wanted %0d",
                                         rsp_last_event, want.last_event));
         end
      end
   end

   // Runs at the register values after reset, before anything is written. Most words
   // are ticks, so time soon passes the 50 ms debounce window measured from zero and
   // presses start to count; early presses show that a fresh key is not accepted
   // right after reset.
   task automatic test_reset_defaults;
      repeat (150) begin
         if ($urandom_range(99) < 80)
            send_word(OP_TICK, 1'b0, LEVEL_RELEASED);
         else
            send_word(OP_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   // Hand-picked sequence with a 2 ms debounce and a 3 ms long press.
   task automatic test_press_and_release;
      write_register(CSR_DEBOUNCE, 16'd2);
      write_register(CSR_LONG_PRESS, 16'd3);
      // Disarm both keys whatever the earlier traffic left behind.
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      send_word(OP_EDGE, 1'b1, LEVEL_RELEASED);
      send_ticks(3);
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      send_word(OP_EDGE, 1'b1, LEVEL_PRESSED);
      // A second press inside the debounce window is dropped.
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      // Quick release gives a short press.
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      // Key 1 reaches the threshold on the third tick.
      send_ticks(3);
      // Re-pressing a held key re-arms it and clears its long flag, so one tick can
      // then report both keys at once.
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      send_word(OP_EDGE, 1'b1, LEVEL_PRESSED);
      send_ticks(3);
      // Releases after a long press stay silent, and a release of a free key too.
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      send_word(OP_EDGE, 1'b1, LEVEL_RELEASED);
      send_word(OP_EDGE, 1'b1, LEVEL_RELEASED);
   endtask

   // A long-press threshold of zero: release never reports a short press, and any
   // held key reports a long press on the next tick.
   task automatic test_zero_threshold;
      write_register(CSR_DEBOUNCE, 16'd0);
      write_register(CSR_LONG_PRESS, 16'd0);
      send_ticks(1);
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      send_word(OP_EDGE, 1'b1, LEVEL_PRESSED);
      send_ticks(2);
      send_word(OP_EDGE, 1'b1, LEVEL_RELEASED);
   endtask

   // Full-scale register values: the largest debounce rejects a press, the largest
   // threshold turns a hold of a few ms into a short press.
   task automatic test_register_extremes;
      write_register(CSR_DEBOUNCE, 16'hFFFF);
      write_register(CSR_LONG_PRESS, 16'hFFFF);
      send_ticks(2);
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      write_register(CSR_DEBOUNCE, 16'd0);
      send_ticks(1);
      send_word(OP_EDGE, 1'b0, LEVEL_PRESSED);
      send_ticks(4);
      send_word(OP_EDGE, 1'b0, LEVEL_RELEASED);
      send_word(OP_EDGE, 1'b1, LEVEL_PRESSED);
      send_word(OP_EDGE, 1'b1, LEVEL_RELEASED);
   endtask

   // One phase of random traffic under fresh small register values. Most of it is
   // press, hold, release on one key with a hold near the threshold, so both short
   // and long presses come up; stray edges on the other key and random words add
   // noise. With pause set, the sender stops once halfway until all owed events are in.
   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input int count, input bit pause);
      int               sent;
      int               hold;
      bit               paused;
      logic             key;
      logic [CFG_W-1:0] debounce_pick;
      logic [CFG_W-1:0] long_pick;
      sent   = 0;
      paused = 1'b0;
      debounce_pick = ($urandom_range(9) == 0) ? 16'd0 : CFG_W'($urandom_range(1, 4));
      long_pick     = ($urandom_range(9) == 0) ? 16'd1 : CFG_W'($urandom_range(2, 12));
      write_register(CSR_DEBOUNCE, debounce_pick);
      write_register(CSR_LONG_PRESS, long_pick);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (sent < count) begin
         if (pause && !paused && sent >= count / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (pending_events.size() != 0)
               @(posedge clock);
            @(posedge clock);
         end
         if ($urandom_range(99) < 70) begin
            key  = 1'($urandom_range(1));
            hold = $urandom_range(int'(long_pick) + 3);
            send_word(OP_EDGE, key, LEVEL_PRESSED);
            repeat (hold) begin
               if ($urandom_range(4) == 0)
                  send_word(OP_EDGE, ~key, 1'($urandom_range(1)));
               else
                  send_word(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            send_word(OP_EDGE, key, LEVEL_RELEASED);
            sent += hold + 2;
            // Let the debounce window run out most of the time before the next press.
            hold = $urandom_range(int'(debounce_pick) + 1);
            send_ticks(hold);
            sent += hold;
         end else begin
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic;
      run_traffic_phase(0, 0, 310, 1'b0);
      run_traffic_phase(46, 0, 310, 1'b1);
      run_traffic_phase(0, 46, 310, 1'b0);
      run_traffic_phase(21, 21, 310, 1'b0);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      int waited;
      ms_now         = '0;
      debounce_now   = DEBOUNCE_RESET;
      long_press_now = LONG_PRESS_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
         press_time[k] = '0;
         armed[k]      = 1'b0;
         long_sent[k]  = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_press_and_release();
      test_zero_threshold();
      test_register_extremes();
      test_random_traffic();

      // Wind down: stop the input, give owed events a bounded time to arrive, then
      // let the pipeline run dry so that a stray extra result is still caught.
      req_valid <= 1'b0;
      waited = 0;
      while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_events.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/kslp_pkg.sv
rtl/core/kslp_classify.sv
rtl/core/kslp_rsp_fifo.sv
rtl/core/key_short_long_press_detector_unit.sv
tb/sv/tb.sv
